@@ hw/rtl/utfd_pkg.sv @@
// Shared types and byte-class constants for the UTF-8 code point decoder.
package utfd_pkg;

  localparam int unsigned CP_W   = 21;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned HIST_N = 3;

  localparam logic [7:0] SFX_MASK = 8'hC0;
  localparam logic [7:0] SFX_CODE = 8'h80;
  localparam logic [7:0] P2_LO    = 8'hC0;
  localparam logic [7:0] P2_HI    = 8'hDF;
  localparam logic [7:0] P3_LO    = 8'hE0;
  localparam logic [7:0] P3_HI    = 8'hEF;
  localparam logic [7:0] P4_LO    = 8'hF0;
  localparam logic [7:0] ASCII_HI = 8'h7F;

  // Per-cell control; clear wins over load, load over shift.
  typedef struct packed {
    logic clear;
    logic load;
    logic shift;
  } cell_ctl_t;

  typedef struct packed {
    logic s42_old;
    logic s43;
    logic s42;
    logic s32;
  } chain_flags_t;

  function automatic logic is_sfx(input logic [7:0] b);
    return (b & SFX_MASK) == SFX_CODE;
  endfunction

  function automatic logic is_p2(input logic [7:0] b);
    return (b >= P2_LO) && (b <= P2_HI);
  endfunction

  function automatic logic is_p3(input logic [7:0] b);
    return (b >= P3_LO) && (b <= P3_HI);
  endfunction

  function automatic logic is_p4(input logic [7:0] b);
    return b >= P4_LO;
  endfunction

  function automatic logic [CP_W-1:0] ascii_part(input logic [7:0] b);
    return (b <= ASCII_HI) ? {13'd0, b} : '0;
  endfunction

endpackage

@@ hw/rtl/utfd_cell.sv @@
// One byte cell of a shift chain: holds a byte and its valid flag.
module utfd_cell (
  input  logic                 clk,
  input  logic                 rst_n,
  input  utfd_pkg::cell_ctl_t  ctl,
  input  logic [7:0]           load_byte,
  input  logic                 load_vld,
  input  logic [7:0]           nbr_byte,
  input  logic                 nbr_vld,
  output logic [7:0]           byte_o,
  output logic                 vld_o
);

  logic [7:0] byte_r, byte_nxt;
  logic       vld_r, vld_nxt;

  always_comb begin
    byte_nxt = byte_r;
    vld_nxt  = vld_r;
    if (ctl.clear) begin
      byte_nxt = '0;
      vld_nxt  = 1'b0;
    end else if (ctl.load) begin
      byte_nxt = load_byte;
      vld_nxt  = load_vld;
    end else if (ctl.shift) begin
      byte_nxt = nbr_byte;
      vld_nxt  = nbr_vld;
    end
  end

  // bytes reset too: empty history slots must read as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_r <= '0;
      vld_r  <= 1'b0;
    end else begin
      byte_r <= byte_nxt;
      vld_r  <= vld_nxt;
    end
  end

  assign byte_o = byte_r;
  assign vld_o  = vld_r;

endmodule

@@ hw/rtl/utfd_la_value.sv @@
// Lookahead value: code point at a prefix byte from up to three later bytes.
module utfd_la_value (
  input  logic [7:0]                  b0,
  input  logic [7:0]                  a1,
  input  logic [7:0]                  a2,
  input  logic [7:0]                  a3,
  output logic [utfd_pkg::CP_W-1:0]   cp
);

  logic [5:0] f1, f2, f3;

  // each later byte counts on its own, no chain check
  assign f1 = utfd_pkg::is_sfx(a1) ? a1[5:0] : 6'd0;
  assign f2 = utfd_pkg::is_sfx(a2) ? a2[5:0] : 6'd0;
  assign f3 = utfd_pkg::is_sfx(a3) ? a3[5:0] : 6'd0;

  always_comb begin
    cp = utfd_pkg::ascii_part(b0);
    if (utfd_pkg::is_p2(b0)) begin
      cp = cp | {10'd0, b0[4:0], f1};
    end
    if (utfd_pkg::is_p3(b0)) begin
      cp = cp | {5'd0, b0[3:0], f1, f2};
    end
    if (utfd_pkg::is_p4(b0)) begin
      cp = cp | {b0[2:0], f1, f2, f3};
    end
  end

endmodule

@@ hw/rtl/utf8_codepoint_decoder.sv @@
// Top level: history chain, flush chain and output register of the decoder.
// Advance mode: one registered result per byte; one byte per cycle when not stalled.
// Lookahead mode: result for a byte comes when the third later byte arrives, one per cycle
//   unless stalled; an end-of-stream byte yields up to four results, one per cycle unless
//   stalled, as the single output register drains the flush chain (no bytes taken then).
// Reset (rst_n low, synchronous) clears history, chain flags, output valid, mode = advance.
module utf8_codepoint_decoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tlast,   // end_of_stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [20:0] code_point, [23:21] zero
  output logic        out_tlast,  // is_last
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_data    // alignment_mode
);

  localparam int unsigned CP_W = utfd_pkg::CP_W;

  logic                   mode_r, mode_nxt;
  utfd_pkg::chain_flags_t fl_r, fl_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [CP_W-1:0]        cp_r, cp_nxt;
  logic                   last_r, last_nxt;

  logic [7:0]             hb [utfd_pkg::HIST_N];
  logic [2:0]             hv;
  logic [7:0]             fb [utfd_pkg::HIST_N];
  logic [2:0]             fv;
  utfd_pkg::cell_ctl_t    h_ctl, f_ctl;

  logic                   in_acc, eos, out_free, flushing;
  logic [7:0]             cur;
  logic [7:0]             w [4];
  logic [7:0]             la_b0, la_a1, la_a2, la_a3;
  logic [CP_W-1:0]        la_cp, adv_cp;

  assign cur       = in_tdata;
  assign eos       = in_tlast;
  assign flushing  = fv[0];
  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = out_free && !flushing;
  assign in_acc    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  // history chain: cell 0 oldest, cell 2 newest
  always_comb begin
    h_ctl       = '0;
    h_ctl.clear = in_acc && eos;
    h_ctl.shift = in_acc && !eos;
  end

  for (genvar i = 0; i < utfd_pkg::HIST_N; i++) begin : g_hist
    if (i == utfd_pkg::HIST_N - 1) begin : g_head
      utfd_cell u_cell (
        .clk(clk), .rst_n(rst_n), .ctl(h_ctl),
        .load_byte(8'd0), .load_vld(1'b0),
        .nbr_byte(cur), .nbr_vld(1'b1),
        .byte_o(hb[i]), .vld_o(hv[i])
      );
    end else begin : g_body
      utfd_cell u_cell (
        .clk(clk), .rst_n(rst_n), .ctl(h_ctl),
        .load_byte(8'd0), .load_vld(1'b0),
        .nbr_byte(hb[i+1]), .nbr_vld(hv[i+1]),
        .byte_o(hb[i]), .vld_o(hv[i])
      );
    end
  end

  // lookahead window aligned to the oldest valid position, zeros past the end
  always_comb begin
    if (hv[0]) begin
      w[0] = hb[0]; w[1] = hb[1]; w[2] = hb[2]; w[3] = cur;
    end else if (hv[1]) begin
      w[0] = hb[1]; w[1] = hb[2]; w[2] = cur;   w[3] = 8'd0;
    end else if (hv[2]) begin
      w[0] = hb[2]; w[1] = cur;   w[2] = 8'd0;  w[3] = 8'd0;
    end else begin
      w[0] = cur;   w[1] = 8'd0;  w[2] = 8'd0;  w[3] = 8'd0;
    end
  end

  // flush chain: loaded with the positions after the first on a lookahead end of stream
  always_comb begin
    f_ctl       = '0;
    f_ctl.load  = in_acc && eos && mode_r;
    f_ctl.shift = flushing && out_free;
  end

  for (genvar i = 0; i < utfd_pkg::HIST_N; i++) begin : g_flush
    if (i == utfd_pkg::HIST_N - 1) begin : g_tail
      utfd_cell u_cell (
        .clk(clk), .rst_n(rst_n), .ctl(f_ctl),
        .load_byte(w[i+1]), .load_vld(hv[utfd_pkg::HIST_N-1-i]),
        .nbr_byte(8'd0), .nbr_vld(1'b0),
        .byte_o(fb[i]), .vld_o(fv[i])
      );
    end else begin : g_body
      utfd_cell u_cell (
        .clk(clk), .rst_n(rst_n), .ctl(f_ctl),
        .load_byte(w[i+1]), .load_vld(hv[utfd_pkg::HIST_N-1-i]),
        .nbr_byte(fb[i+1]), .nbr_vld(fv[i+1]),
        .byte_o(fb[i]), .vld_o(fv[i])
      );
    end
  end

  assign la_b0 = flushing ? fb[0] : w[0];
  assign la_a1 = flushing ? fb[1] : w[1];
  assign la_a2 = flushing ? fb[2] : w[2];
  assign la_a3 = flushing ? 8'd0  : w[3];

  utfd_la_value u_la (
    .b0(la_b0), .a1(la_a1), .a2(la_a2), .a3(la_a3), .cp(la_cp)
  );

  // advance value: b0 = cur, b1 = hb[2], b2 = hb[1], b3 = hb[0]
  always_comb begin
    logic s0;
    s0     = utfd_pkg::is_sfx(cur);
    adv_cp = utfd_pkg::ascii_part(cur);
    if (utfd_pkg::is_p2(hb[2])) begin
      adv_cp = adv_cp | {10'd0, hb[2][4:0], 6'd0};
      if (s0) adv_cp = adv_cp | {15'd0, cur[5:0]};
    end
    if (utfd_pkg::is_p3(hb[1])) adv_cp = adv_cp | {5'd0, hb[1][3:0], 12'd0};
    if (fl_r.s32 || fl_r.s43) begin
      adv_cp = adv_cp | {9'd0, hb[2][5:0], 6'd0};
      if (s0) adv_cp = adv_cp | {15'd0, cur[5:0]};
    end
    if (utfd_pkg::is_p4(hb[0])) adv_cp = adv_cp | {hb[0][2:0], 18'd0};
    if (fl_r.s42_old) adv_cp = adv_cp | {3'd0, hb[1][5:0], 12'd0};
  end

  always_comb begin
    fl_nxt = fl_r;
    if (in_acc) begin
      if (eos) begin
        fl_nxt = '0;
      end else begin
        fl_nxt.s32     = utfd_pkg::is_sfx(cur) && utfd_pkg::is_p3(hb[2]);
        fl_nxt.s42     = utfd_pkg::is_sfx(cur) && utfd_pkg::is_p4(hb[2]);
        fl_nxt.s43     = utfd_pkg::is_sfx(cur) && fl_r.s42;
        fl_nxt.s42_old = fl_r.s42;
      end
    end
  end

  always_comb begin
    mode_nxt      = (cfg_valid && cfg_ready) ? cfg_data : mode_r;
    out_valid_nxt = out_valid_r;
    cp_nxt        = cp_r;
    last_nxt      = last_r;
    if (flushing && out_free) begin
      out_valid_nxt = 1'b1;
      cp_nxt        = la_cp;
      last_nxt      = !fv[1];
    end else if (in_acc) begin
      if (!mode_r) begin
        out_valid_nxt = 1'b1;
        cp_nxt        = adv_cp;
        last_nxt      = eos;
      end else if (eos) begin
        // first flushed position; last when nothing else is held
        out_valid_nxt = 1'b1;
        cp_nxt        = la_cp;
        last_nxt      = !hv[2];
      end else begin
        out_valid_nxt = hv[0];
        cp_nxt        = la_cp;
        last_nxt      = 1'b0;
      end
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= 1'b0;
      fl_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      mode_r      <= mode_nxt;
      fl_r        <= fl_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cp_r   <= cp_nxt;
    last_r <= last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'd0, cp_r};
  assign out_tlast  = last_r;

  a_no_take_while_flush: assert property (@(posedge clk) disable iff (!rst_n)
    flushing |-> !in_tready)
    else $error("byte taken while flush chain busy");

  a_hist_contig: assert property (@(posedge clk) disable iff (!rst_n)
    (hv[0] |-> hv[1]) and (hv[1] |-> hv[2]))
    else $error("history valid bits not contiguous");

  a_flush_contig: assert property (@(posedge clk) disable iff (!rst_n)
    (fv[2] |-> fv[1]) and (fv[1] |-> fv[0]))
    else $error("flush valid bits not contiguous");

  a_eos_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && eos) |=> (hv == 3'd0) && (fl_r == '0))
    else $error("history not cleared after end of stream");

  a_adv_eos_last: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && eos && !mode_r) |=> (out_tvalid && out_tlast && !flushing))
    else $error("advance end of stream result missing last flag");

endmodule
